/* rtl/mcw_pkg.sv */
// ----------------------------------------------------------------------------
// mcw_pkg
// shared types, codes and helpers of the heartbeat watchdog
// ----------------------------------------------------------------------------
package mcw_pkg;

  localparam int CLIENTS_DEF = 16;
  localparam int STAMP_W     = 32;
  localparam int INTERVAL_W  = 16;
  localparam int CNT_W       = 5;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

  // input kinds
  localparam logic [2:0] KIND_ADD       = 3'd0;
  localparam logic [2:0] KIND_REMOVE    = 3'd1;
  localparam logic [2:0] KIND_HEARTBEAT = 3'd2;
  localparam logic [2:0] KIND_QUERY     = 3'd3;
  localparam logic [2:0] KIND_TICK      = 3'd4;

  // result events
  localparam logic [1:0] EV_ACK     = 2'd0;
  localparam logic [1:0] EV_MISSING = 2'd1;
  localparam logic [1:0] EV_EMPTY   = 2'd2;

  // modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ANY   = 2'd1;
  localparam logic [1:0] MODE_EMPTY = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] client;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [3:0]       who;
    logic             alarm;
    logic             alive;
    logic [CNT_W-1:0] remaining;
    logic             last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  function automatic logic mode_enabled(input logic [1:0] mode);
    return (mode == MODE_ANY) || (mode == MODE_EMPTY);
  endfunction

  function automatic logic miss_alarm(input logic [1:0] mode, input logic [CNT_W-1:0] rem);
    return (mode == MODE_ANY) || ((mode == MODE_EMPTY) && (rem == '0));
  endfunction

endpackage

/* rtl/mcw_stamp_mem.sv */
// ----------------------------------------------------------------------------
// mcw_stamp_mem
// heartbeat time stamp memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module mcw_stamp_mem #(
  parameter  int DEPTH = mcw_pkg::CLIENTS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [mcw_pkg::STAMP_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [mcw_pkg::STAMP_W-1:0]  rd_data
);

  logic [mcw_pkg::STAMP_W-1:0] mem [DEPTH];
  logic [mcw_pkg::STAMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/multi_client_heartbeat_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// multi_client_heartbeat_watchdog_unit
// heartbeat watchdog over numbered client slots with periodic health check
// ----------------------------------------------------------------------------
// Add, remove, heartbeat and query each show their single result in the cycle
// after start; busy stays low, so the next word can follow at once. A tick that
// runs no health check, or one that finds no clients, also leaves busy low. A
// tick that runs a check over registered clients keeps busy high through the
// scan, drain and flush states: the stamp memory has one read port and the scan
// reads one slot per cycle, then drains its compare stage and flushes the held
// result. Stale clients come out in ascending slot order, one strobe each,
// possibly with gaps; the last one carries last. The receiver cannot stall:
// every out_strobe pulse must be taken. Configuration writes are taken while
// busy is low and no word is being started.
module multi_client_heartbeat_watchdog_unit #(
  parameter int CLIENTS = mcw_pkg::CLIENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  mcw_pkg::in_word_t                     in_word,
  output logic                                  out_strobe,
  output mcw_pkg::out_word_t                    out_word,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mcw_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [mcw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CLIENTS - 1);

  mcw_pkg::state_t state_r, state_nxt;

  logic [1:0]                        mode_r, mode_nxt;
  logic [mcw_pkg::INTERVAL_W-1:0]    interval_r, interval_nxt;
  logic [CLIENTS-1:0]                valid_r, valid_nxt;
  logic [mcw_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [mcw_pkg::STAMP_W-1:0]       now_r, now_nxt;
  logic [mcw_pkg::INTERVAL_W-1:0]    cd_r, cd_nxt;

  logic                              out_strobe_r, out_strobe_nxt;
  mcw_pkg::out_word_t                out_word_r, out_word_nxt;
  logic                              pend_vld_r, pend_vld_nxt;
  mcw_pkg::out_word_t                pend_r, pend_nxt;
  logic [IW-1:0]                     scan_idx_r, scan_idx_nxt;
  logic                              chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]                     chk_idx_r, chk_idx_nxt;

  logic                              in_accept;
  logic                              scan_go;
  logic                              rd_en;
  logic                              inr;
  logic [IW-1:0]                     cl_idx;
  logic                              cl_valid;
  logic [mcw_pkg::INTERVAL_W-1:0]    eff;
  logic [mcw_pkg::STAMP_W-1:0]       rd_stamp;
  logic [mcw_pkg::STAMP_W-1:0]       age;
  logic                              stale;
  logic [mcw_pkg::CNT_W-1:0]         scan_rem;
  logic [mcw_pkg::CNT_W-1:0]         rm_rem;
  logic                              wr_en;

  assign in_accept = start && !busy;
  assign inr       = 32'(in_word.client) < CLIENTS;
  assign cl_idx    = IW'(in_word.client);
  assign cl_valid  = inr && valid_r[cl_idx];
  assign eff       = (interval_r == '0) ? mcw_pkg::INTERVAL_W'(1) : interval_r;
  assign age       = now_r - rd_stamp;
  assign stale     = chk_vld_r && valid_r[chk_idx_r] &&
                     (age > mcw_pkg::STAMP_W'(eff));
  assign scan_rem  = cnt_r - mcw_pkg::CNT_W'(1);
  assign rm_rem    = cl_valid ? cnt_r - mcw_pkg::CNT_W'(1) : cnt_r;
  assign wr_en     = in_accept && inr &&
                     ((in_word.kind == mcw_pkg::KIND_ADD) ||
                      (in_word.kind == mcw_pkg::KIND_HEARTBEAT));

  mcw_stamp_mem #(
    .DEPTH(CLIENTS)
  ) u_stamp_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cl_idx),
    .wr_data (now_r),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (rd_stamp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcw_pkg::ST_IDLE: begin
        if (scan_go) begin
          state_nxt = mcw_pkg::ST_SCAN;
        end
      end
      mcw_pkg::ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = mcw_pkg::ST_DRAIN;
        end
      end
      mcw_pkg::ST_DRAIN: begin
        state_nxt = mcw_pkg::ST_FLUSH;
      end
      mcw_pkg::ST_FLUSH: begin
        state_nxt = mcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mcw_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy      = (state_r != mcw_pkg::ST_IDLE);
    cfg_ready = (state_r == mcw_pkg::ST_IDLE) && !start;
    rd_en     = (state_r == mcw_pkg::ST_SCAN);
  end

  // datapath
  always_comb begin
    mode_nxt       = mode_r;
    interval_nxt   = interval_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    cd_nxt         = cd_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    scan_go        = 1'b0;
    scan_idx_nxt   = scan_idx_r;
    chk_vld_nxt    = (state_r == mcw_pkg::ST_SCAN);
    chk_idx_nxt    = scan_idx_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcw_pkg::REG_MODE: begin
          mode_nxt = cfg_data[1:0];
          if (mcw_pkg::mode_enabled(cfg_data[1:0])) begin
            valid_nxt = '0;
            cnt_nxt   = '0;
            cd_nxt    = '0;
          end
        end
        mcw_pkg::REG_INTERVAL: begin
          interval_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end

    if (in_accept) begin
      out_word_nxt.event_res = mcw_pkg::EV_ACK;
      out_word_nxt.who       = in_word.client;
      out_word_nxt.alarm     = 1'b0;
      out_word_nxt.alive     = 1'b0;
      out_word_nxt.remaining = cnt_r;
      out_word_nxt.last      = 1'b1;
      unique case (in_word.kind) inside
        mcw_pkg::KIND_ADD, mcw_pkg::KIND_HEARTBEAT: begin
          out_strobe_nxt = 1'b1;
          if (inr) begin
            valid_nxt[cl_idx] = 1'b1;
            if (!valid_r[cl_idx]) begin
              cnt_nxt = cnt_r + mcw_pkg::CNT_W'(1);
            end
          end
          out_word_nxt.remaining = (inr && !valid_r[cl_idx]) ?
                                   cnt_r + mcw_pkg::CNT_W'(1) : cnt_r;
        end
        mcw_pkg::KIND_REMOVE: begin
          out_strobe_nxt = 1'b1;
          if (inr) begin
            valid_nxt[cl_idx] = 1'b0;
          end
          cnt_nxt                = rm_rem;
          out_word_nxt.remaining = rm_rem;
          if (cnt_r <= mcw_pkg::CNT_W'(1)) begin
            out_word_nxt.event_res = mcw_pkg::EV_MISSING;
            out_word_nxt.alarm     = mcw_pkg::miss_alarm(mode_r, rm_rem);
          end
        end
        mcw_pkg::KIND_QUERY: begin
          out_strobe_nxt     = 1'b1;
          out_word_nxt.alive = cl_valid;
        end
        mcw_pkg::KIND_TICK: begin
          now_nxt = now_r + mcw_pkg::STAMP_W'(1);
          if (mcw_pkg::mode_enabled(mode_r)) begin
            if (cd_r != '0) begin
              cd_nxt = cd_r - mcw_pkg::INTERVAL_W'(1);
            end else begin
              cd_nxt = eff - mcw_pkg::INTERVAL_W'(1);
              if (cnt_r == '0) begin
                out_strobe_nxt         = 1'b1;
                out_word_nxt.event_res = mcw_pkg::EV_EMPTY;
                out_word_nxt.who       = '0;
                out_word_nxt.alarm     = 1'b1;
                out_word_nxt.remaining = '0;
              end else begin
                scan_go      = 1'b1;
                scan_idx_nxt = '0;
                pend_vld_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == mcw_pkg::ST_SCAN) begin
      scan_idx_nxt = scan_idx_r + IW'(1);
    end

    // stale slot: release the held result, hold the new one
    if (stale) begin
      valid_nxt[chk_idx_r] = 1'b0;
      cnt_nxt              = scan_rem;
      if (pend_vld_r) begin
        out_strobe_nxt    = 1'b1;
        out_word_nxt      = pend_r;
        out_word_nxt.last = 1'b0;
      end
      pend_vld_nxt       = 1'b1;
      pend_nxt.event_res = mcw_pkg::EV_MISSING;
      pend_nxt.who       = 4'(chk_idx_r);
      pend_nxt.alarm     = mcw_pkg::miss_alarm(mode_r, scan_rem);
      pend_nxt.alive     = 1'b0;
      pend_nxt.remaining = scan_rem;
      pend_nxt.last      = 1'b0;
    end

    if (state_r == mcw_pkg::ST_FLUSH) begin
      pend_vld_nxt = 1'b0;
      if (pend_vld_r) begin
        out_strobe_nxt    = 1'b1;
        out_word_nxt      = pend_r;
        out_word_nxt.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mcw_pkg::ST_IDLE;
      mode_r       <= mcw_pkg::MODE_OFF;
      interval_r   <= mcw_pkg::INTERVAL_RESET;
      valid_r      <= '0;
      cnt_r        <= '0;
      now_r        <= '0;
      cd_r         <= '0;
      out_strobe_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      chk_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      interval_r   <= interval_nxt;
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      now_r        <= now_nxt;
      cd_r         <= cd_nxt;
      out_strobe_r <= out_strobe_nxt;
      pend_vld_r   <= pend_vld_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    pend_r     <= pend_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(valid_r))
    else $error("client count out of step with valid bits");

  a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcw_pkg::ST_IDLE) |-> (!chk_vld_r && !pend_vld_r))
    else $error("scan stage active while idle");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_word_r.event_res == mcw_pkg::EV_EMPTY)) |->
      (out_word_r.alarm && (out_word_r.remaining == '0) && out_word_r.last))
    else $error("no-clients result malformed");

  a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcw_pkg::ST_SCAN) |=> (state_r != mcw_pkg::ST_IDLE))
    else $error("scan ended without drain and flush");

endmodule

/* bench/tb_multi_client_heartbeat_watchdog_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_client_heartbeat_watchdog_unit
// Self-checking bench for the heartbeat watchdog. Commands and ticks are
// driven with random gaps. A slot table model predicts every result word,
// health check reports included, and each strobed word is compared with it.
// ----------------------------------------------------------------------------

class slot_watch_model;
  logic [1:0]                   mode;
  logic [15:0]                  interval;
  bit                           slot_on[mcw_pkg::CLIENTS_DEF];
  logic [31:0]                  slot_time[mcw_pkg::CLIENTS_DEF];
  logic [31:0]                  now_ms;
  logic [15:0]                  countdown;
  mcw_pkg::out_word_t           due_reports[$];
  int unsigned                  bad_count;

  function new();
    mode      = mcw_pkg::MODE_OFF;
    interval  = mcw_pkg::INTERVAL_RESET;
    now_ms    = '0;
    countdown = '0;
    bad_count = 0;
    foreach (slot_on[i]) begin
      slot_on[i]   = 1'b0;
      slot_time[i] = '0;
    end
  endfunction

  function int unsigned live();
    int unsigned n;
    n = 0;
    foreach (slot_on[i]) if (slot_on[i]) n++;
    return n;
  endfunction

  function logic [31:0] period();
    return (interval == 16'd0) ? 32'd1 : {16'd0, interval};
  endfunction

  function bit armed();
    return (mode == mcw_pkg::MODE_ANY) || (mode == mcw_pkg::MODE_EMPTY);
  endfunction

  function void post(logic [1:0] ev, logic [3:0] who, logic alarm, logic alive);
    mcw_pkg::out_word_t r;
    r.event_res = ev;
    r.who       = who;
    r.alarm     = alarm;
    r.alive     = alive;
    r.remaining = 5'(live());
    r.last      = 1'b0;
    due_reports.insert(due_reports.size(), r);
  endfunction

  // erase the slot and report it missing
  function void drop_missing(logic [3:0] s);
    slot_on[s] = 1'b0;
    post(mcw_pkg::EV_MISSING, s,
         (mode == mcw_pkg::MODE_ANY) || (mode == mcw_pkg::MODE_EMPTY && live() == 0), 1'b0);
  endfunction

  function void write_reg(logic [mcw_pkg::REG_IDX_W-1:0] idx,
                          logic [mcw_pkg::CFG_DATA_W-1:0] data);
    if (idx == mcw_pkg::REG_MODE) begin
      mode = data[1:0];
      if (armed()) begin
        foreach (slot_on[i]) slot_on[i] = 1'b0;
        countdown = '0;
      end
    end else if (idx == mcw_pkg::REG_INTERVAL) begin
      interval = data[15:0];
    end
  endfunction

  function void take_command(mcw_pkg::in_word_t w);
    int unsigned        prior_size;
    mcw_pkg::out_word_t r;
    prior_size = due_reports.size();
    case (w.kind)
      mcw_pkg::KIND_ADD, mcw_pkg::KIND_HEARTBEAT: begin
        slot_on[w.client]   = 1'b1;
        slot_time[w.client] = now_ms;
        post(mcw_pkg::EV_ACK, w.client, 1'b0, 1'b0);
      end
      mcw_pkg::KIND_REMOVE: begin
        if (live() > 1) begin
          slot_on[w.client] = 1'b0;
          post(mcw_pkg::EV_ACK, w.client, 1'b0, 1'b0);
        end else begin
          drop_missing(w.client);
        end
      end
      mcw_pkg::KIND_QUERY: begin
        post(mcw_pkg::EV_ACK, w.client, 1'b0, slot_on[w.client]);
      end
      mcw_pkg::KIND_TICK: begin
        now_ms = now_ms + 32'd1;
        if (armed()) begin
          if (countdown != 16'd0) begin
            countdown = countdown - 16'd1;
          end else begin
            countdown = 16'(period() - 32'd1);
            if (live() == 0) begin
              post(mcw_pkg::EV_EMPTY, 4'd0, 1'b1, 1'b0);
            end else begin
              for (int i = 0; i < mcw_pkg::CLIENTS_DEF; i++) begin
                if (slot_on[i] && (32'(now_ms - slot_time[i]) > period()))
                  drop_missing(4'(i));
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (due_reports.size() > prior_size) begin
      r = due_reports[due_reports.size()-1];
      r.last = 1'b1;
      due_reports[due_reports.size()-1] = r;
    end
  endfunction

  function void take_report(mcw_pkg::out_word_t got);
    mcw_pkg::out_word_t want;
    if (due_reports.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("unexpected word: ev=%0d who=%0d alarm=%0d alive=%0d rem=%0d last=%0d",
                 got.event_res, got.who, got.alarm, got.alive, got.remaining, got.last);
      return;
    end
    want = due_reports.pop_front();
    if (got.event_res !== want.event_res || got.who !== want.who ||
        got.alarm !== want.alarm || got.alive !== want.alive ||
        got.remaining !== want.remaining || got.last !== want.last) begin
      bad_count++;
      if (bad_count <= 10)
        $display("mismatch: exp ev=%0d who=%0d alarm=%0d alive=%0d rem=%0d last=%0d",
                 want.event_res, want.who, want.alarm, want.alive, want.remaining,
                 want.last,
                 " / got ev=%0d who=%0d alarm=%0d alive=%0d rem=%0d last=%0d",
                 got.event_res, got.who, got.alarm, got.alive,
                 got.remaining, got.last);
    end
  endfunction
endclass

module tb_multi_client_heartbeat_watchdog_unit;

  localparam logic [2:0]                    KIND_ODD   = 3'd5;
  localparam logic [2:0]                    KIND_TOP   = 3'd7;
  localparam logic [1:0]                    MODE_SPARE = 2'd3;
  localparam logic [mcw_pkg::REG_IDX_W-1:0] REG_SPARE  = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  mcw_pkg::in_word_t              in_word;
  logic                           out_strobe;
  mcw_pkg::out_word_t             out_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mcw_pkg::REG_IDX_W-1:0]  cfg_index;
  logic [mcw_pkg::CFG_DATA_W-1:0] cfg_data;

  slot_watch_model book;
  bit              steady = 1'b0;

  multi_client_heartbeat_watchdog_unit #(.CLIENTS(mcw_pkg::CLIENTS_DEF)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // results first, then the word taken at this edge
  always @(posedge clk) begin
    if (rst_n && book != null) begin
      if (out_strobe) book.take_report(out_word);
      if (start && !busy) book.take_command(in_word);
      if (cfg_valid && cfg_ready) book.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned n;
    n = 0;
    if (steady) return 0;
    while ($urandom_range(99) < 34) n++;
    return n;
  endfunction

  task automatic send(logic [2:0] op, logic [3:0] slot);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= '{kind: op, client: slot};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (book.due_reports.size() != 0 || busy) @(posedge clk);
    repeat (mcw_pkg::CLIENTS_DEF + 4) @(posedge clk);
  endtask

  task automatic set_reg(logic [mcw_pkg::REG_IDX_W-1:0] idx,
                         logic [mcw_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [1:0] md, logic [15:0] iv, int unsigned count, bit calm);
    int unsigned roll;
    int unsigned done;
    logic [2:0]  op;
    logic [3:0]  slot;
    settle();
    set_reg(mcw_pkg::REG_INTERVAL, iv);
    set_reg(mcw_pkg::REG_MODE, {14'd0, md});
    steady = calm;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      // a few hot slots so heartbeats keep clients alive
      if ($urandom_range(99) < 70) slot = 4'($urandom_range(3));
      else slot = 4'($urandom_range(15));
      if (roll < 32)      op = mcw_pkg::KIND_TICK;
      else if (roll < 56) op = mcw_pkg::KIND_HEARTBEAT;
      else if (roll < 70) op = mcw_pkg::KIND_ADD;
      else if (roll < 82) op = mcw_pkg::KIND_REMOVE;
      else if (roll < 94) op = mcw_pkg::KIND_QUERY;
      else                op = 3'($urandom_range(KIND_ODD, KIND_TOP));
      send(op, slot);
      if (op <= mcw_pkg::KIND_TICK) done++;
    end
    steady = 1'b0;
  endtask

  initial begin
    book      = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mcw_pkg::REG_MODE;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // watchdog off: plain commands, last-client remove, ignored kinds
    send(mcw_pkg::KIND_QUERY, 4'd0);
    send(mcw_pkg::KIND_ADD, 4'd15);
    send(mcw_pkg::KIND_ADD, 4'd0);
    send(mcw_pkg::KIND_HEARTBEAT, 4'd15);
    send(mcw_pkg::KIND_QUERY, 4'd15);
    send(mcw_pkg::KIND_REMOVE, 4'd15);
    send(mcw_pkg::KIND_REMOVE, 4'd0);
    send(mcw_pkg::KIND_REMOVE, 4'd7);
    send(mcw_pkg::KIND_TICK, 4'd0);
    send(KIND_TOP, 4'd15);
    send(KIND_ODD, 4'd10);

    // any-missing mode: empty check, then two clients going stale
    settle();
    set_reg(mcw_pkg::REG_INTERVAL, 16'd2);
    set_reg(mcw_pkg::REG_MODE, {14'd0, mcw_pkg::MODE_ANY});
    send(mcw_pkg::KIND_TICK, 4'd0);
    send(mcw_pkg::KIND_ADD, 4'd3);
    send(mcw_pkg::KIND_ADD, 4'd12);
    repeat (4) send(mcw_pkg::KIND_TICK, 4'd0);

    // none-remain mode
    settle();
    set_reg(mcw_pkg::REG_MODE, {14'd0, mcw_pkg::MODE_EMPTY});
    send(mcw_pkg::KIND_ADD, 4'd5);
    send(mcw_pkg::KIND_REMOVE, 4'd5);
    send(mcw_pkg::KIND_TICK, 4'd0);
    send(mcw_pkg::KIND_ADD, 4'd9);
    send(mcw_pkg::KIND_ADD, 4'd2);
    send(mcw_pkg::KIND_REMOVE, 4'd9);

    run_phase(mcw_pkg::MODE_ANY,   16'd3,     35, 1'b0);
    run_phase(mcw_pkg::MODE_EMPTY, 16'd5,     35, 1'b0);
    run_phase(mcw_pkg::MODE_ANY,   16'd0,     30, 1'b1);
    run_phase(MODE_SPARE,          16'd2,     25, 1'b0);
    run_phase(mcw_pkg::MODE_EMPTY, 16'hFFFF,  25, 1'b0);
    run_phase(mcw_pkg::MODE_ANY,   16'd1,     35, 1'b0);
    settle();
    set_reg(REG_SPARE, 16'hFFFF);
    run_phase(mcw_pkg::MODE_OFF,   16'd4,     25, 1'b0);
    run_phase(mcw_pkg::MODE_EMPTY, 16'd8,     35, 1'b0);
    run_phase(mcw_pkg::MODE_ANY,   16'd6,     35, 1'b0);
    settle();

    if (book.bad_count == 0 && book.due_reports.size() == 0) begin
      $display("tb_multi_client_heartbeat_watchdog_unit: clean");
    end else begin
      $display("tb_multi_client_heartbeat_watchdog_unit: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_multi_client_heartbeat_watchdog_unit: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/mcw_pkg.sv
rtl/mcw_stamp_mem.sv
rtl/multi_client_heartbeat_watchdog_unit.sv
bench/tb_multi_client_heartbeat_watchdog_unit.sv
